FILE: src/blcb_pkg.sv
// ---------------------------------------------------------------------------
// blcb_pkg
// Shared types and constants of the backlight contrast and brightness pipeline.
// ---------------------------------------------------------------------------
package blcb_pkg;

	// Luma weights in Q16. They sum to 65536.
	localparam logic [15:0] LUMA_W_RED   = 16'd19595;
	localparam logic [15:0] LUMA_W_GREEN = 16'd38470;
	localparam logic [15:0] LUMA_W_BLUE  = 16'd7471;

	// Widths of the gain and offset terms.
	localparam int ALPHA_W = 18;   // Q12, signed
	localparam int BETA_W  = 24;   // Q12, signed

	// Unity gain in Q12.
	localparam logic signed [ALPHA_W-1:0] ALPHA_ONE = 18'sd4096;

	typedef enum logic [1:0] {
		REG_GAIN_MAX      = 2'd0,
		REG_OFFSET_STR    = 2'd1,
		REG_GAIN_SHIFT    = 2'd2,
		REG_OFFSET_SHIFT  = 2'd3
	} blcb_reg_t;

	typedef struct packed {
		logic [9:0] gain_max_q8;
		logic [7:0] offset_strength;
		logic [6:0] gain_luma_shift;
		logic [6:0] offset_luma_shift;
	} blcb_cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} blcb_pix_t;

endpackage

FILE: src/blcb_luma.sv
// ---------------------------------------------------------------------------
// blcb_luma
// First pipeline stage: registers the pixel together with its Q8 luma.
// ---------------------------------------------------------------------------
module blcb_luma (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  blcb_pkg::blcb_pix_t pix_in,
	output logic               dn_valid,
	input  logic               dn_ready,
	output blcb_pkg::blcb_pix_t pix_out,
	output logic [15:0]        luma_out
);
	import blcb_pkg::*;

	logic        valid_s1;
	blcb_pix_t   pix_s1;
	logic [15:0] luma_s1;
	logic [24:0] y16;

	assign up_ready = !valid_s1 || dn_ready;

	// Q16 weighted sum plus half an LSB of the Q8 result.
	assign y16 = 25'(LUMA_W_RED * pix_in.red) + 25'(LUMA_W_GREEN * pix_in.green)
		+ 25'(LUMA_W_BLUE * pix_in.blue) + 25'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			pix_s1  <= pix_in;
			luma_s1 <= y16[23:8];
		end
	end

	assign dn_valid = valid_s1;
	assign pix_out  = pix_s1;
	assign luma_out = luma_s1;

endmodule

FILE: src/blcb_curve.sv
// ---------------------------------------------------------------------------
// blcb_curve
// Three stages that turn luma into the contrast gain and brightness offset.
// ---------------------------------------------------------------------------
module blcb_curve (
	input  logic                                clk,
	input  logic                                arst_n,
	input  blcb_pkg::blcb_cfg_t                 cfg,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  blcb_pkg::blcb_pix_t                 pix_in,
	input  logic [15:0]                         luma_in,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output blcb_pkg::blcb_pix_t                 pix_out,
	output logic signed [blcb_pkg::ALPHA_W-1:0] alpha_out,
	output logic signed [blcb_pkg::BETA_W-1:0]  beta_out
);
	import blcb_pkg::*;

	logic valid_s2, valid_s3, valid_s4;
	logic rdy_s2, rdy_s3, rdy_s4;

	// Stage 2: distances from the two curve centers, squared.
	logic [15:0]        center_a, center_b;
	logic [7:0]         cb_hi;
	logic signed [16:0] da, db;
	logic [15:0]        da_mag, db_mag;

	blcb_pix_t          pix_s2;
	logic [31:0]        da_sq_s2, db_sq_s2;
	logic [23:0]        bdb_s2;
	logic               db_neg_s2;
	logic signed [10:0] k_s2;

	// Stage 3: gain and offset products.
	blcb_pix_t          pix_s3;
	logic signed [43:0] ka_s3;
	logic [55:0]        bp_s3;
	logic               db_neg_s3;
	logic signed [43:0] ka;
	logic signed [32:0] da_sq_sgn;

	// Stage 4: rounding to Q12.
	blcb_pix_t                  pix_s4;
	logic signed [ALPHA_W-1:0]  alpha_s4;
	logic signed [BETA_W-1:0]   beta_s4;
	logic signed [43:0]         ka_rnd;
	logic signed [56:0]         bp_sgn, bp_rnd;

	assign rdy_s4   = !valid_s4 || dn_ready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign up_ready = rdy_s2;

	assign center_a = {1'b1, cfg.gain_luma_shift, 8'h00};
	assign cb_hi    = 8'd128 - {1'b0, cfg.offset_luma_shift};
	assign center_b = {cb_hi, 8'h00};
	assign da       = $signed({1'b0, luma_in}) - $signed({1'b0, center_a});
	assign db       = $signed({1'b0, center_b}) - $signed({1'b0, luma_in});
	assign da_mag   = da[16] ? 16'(-da) : da[15:0];
	assign db_mag   = db[16] ? 16'(-db) : db[15:0];

	assign da_sq_sgn = $signed({1'b0, da_sq_s2});
	assign ka        = k_s2 * da_sq_sgn;

	// Both roundings are floor(x + 1/2); an arithmetic shift is the floor.
	assign ka_rnd = ka_s3 + 44'sd33554432;
	assign bp_sgn = db_neg_s3 ? -$signed({1'b0, bp_s3}) : $signed({1'b0, bp_s3});
	assign bp_rnd = bp_sgn + 57'sd4294967296;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				valid_s2 <= up_valid;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s2) begin
			pix_s2    <= pix_in;
			da_sq_s2  <= da_mag * da_mag;
			db_sq_s2  <= db_mag * db_mag;
			bdb_s2    <= cfg.offset_strength * db_mag;
			db_neg_s2 <= db[16];
			k_s2      <= $signed({1'b0, cfg.gain_max_q8}) - 11'sd256;
		end
		if (valid_s2 && rdy_s3) begin
			pix_s3    <= pix_s2;
			ka_s3     <= ka;
			bp_s3     <= db_sq_s2 * bdb_s2;
			db_neg_s3 <= db_neg_s2;
		end
		if (valid_s3 && rdy_s4) begin
			pix_s4   <= pix_s3;
			alpha_s4 <= ka_rnd[43:26] + ALPHA_ONE;
			beta_s4  <= bp_rnd[56:33];
		end
	end

	assign dn_valid  = valid_s4;
	assign pix_out   = pix_s4;
	assign alpha_out = alpha_s4;
	assign beta_out  = beta_s4;

endmodule

FILE: src/blcb_apply.sv
// ---------------------------------------------------------------------------
// blcb_apply
// Last stage: applies gain and offset to each channel, rounds and clamps.
// ---------------------------------------------------------------------------
module blcb_apply (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  blcb_pkg::blcb_pix_t                 pix_in,
	input  logic signed [blcb_pkg::ALPHA_W-1:0] alpha_in,
	input  logic signed [blcb_pkg::BETA_W-1:0]  beta_in,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output blcb_pkg::blcb_pix_t                 pix_out
);
	import blcb_pkg::*;

	logic      valid_s5;
	blcb_pix_t pix_s5;
	blcb_pix_t pix_new;

	function automatic logic [7:0] apply_chan(
		input logic [7:0]                c,
		input logic signed [ALPHA_W-1:0] alpha,
		input logic signed [BETA_W-1:0]  beta
	);
		logic signed [27:0] prod;
		logic signed [27:0] acc;
		logic signed [15:0] res;
		logic [7:0]         val;
		prod = $signed({1'b0, c}) * alpha;
		acc  = prod + 28'(beta) + 28'sd2048;
		res  = acc[27:12];
		if (res < 16'sd0) begin
			val = 8'd0;
		end else if (res > 16'sd255) begin
			val = 8'd255;
		end else begin
			val = res[7:0];
		end
		return val;
	endfunction

	assign pix_new.red   = apply_chan(pix_in.red, alpha_in, beta_in);
	assign pix_new.green = apply_chan(pix_in.green, alpha_in, beta_in);
	assign pix_new.blue  = apply_chan(pix_in.blue, alpha_in, beta_in);

	assign up_ready = !valid_s5 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (up_ready) begin
			valid_s5 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			pix_s5 <= pix_new;
		end
	end

	assign dn_valid = valid_s5;
	assign pix_out  = pix_s5;

endmodule

FILE: src/backlit_luma_contrast_brightness_top.sv
// ---------------------------------------------------------------------------
// backlit_luma_contrast_brightness_top
// Backlight compensation: luma-driven contrast gain and brightness offset.
// ---------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid / in_stall     red_in, green_in, blue_in
//  out      out_valid / out_stall   red_out, green_out, blue_out
//  cfg      cfg_we                  cfg_index, cfg_data
//
//  Five register stages: luma, center distances and squares, gain and offset
//  products, Q12 rounding, channel apply and clamp. One item is taken every
//  cycle while in_stall is low.
//  Reset clears the stage valid bits and loads the register defaults.
//  Each stage holds while the one after it is full and stalled, so bubbles
//  close up and in_stall rises only when all five stages are full.
// ---------------------------------------------------------------------------
module backlit_luma_contrast_brightness_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	import blcb_pkg::*;

	blcb_cfg_t cfg_q;

	blcb_pix_t pix_in, pix_l, pix_c, pix_o;
	logic [15:0] luma_l;
	logic signed [ALPHA_W-1:0] alpha_c;
	logic signed [BETA_W-1:0]  beta_c;
	logic in_ready, l_valid, c_ready, c_valid, a_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_max_q8       <= 10'd333;
			cfg_q.offset_strength   <= 8'd50;
			cfg_q.gain_luma_shift   <= 7'd48;
			cfg_q.offset_luma_shift <= 7'd48;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_MAX:     cfg_q.gain_max_q8       <= cfg_data;
				REG_OFFSET_STR:   cfg_q.offset_strength   <= cfg_data[7:0];
				REG_GAIN_SHIFT:   cfg_q.gain_luma_shift   <= cfg_data[6:0];
				REG_OFFSET_SHIFT: cfg_q.offset_luma_shift <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign pix_in.red   = red_in;
	assign pix_in.green = green_in;
	assign pix_in.blue  = blue_in;
	assign in_stall     = !in_ready;

	blcb_luma u_luma (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.pix_in   (pix_in),
		.dn_valid (l_valid),
		.dn_ready (c_ready),
		.pix_out  (pix_l),
		.luma_out (luma_l)
	);

	blcb_curve u_curve (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.up_valid  (l_valid),
		.up_ready  (c_ready),
		.pix_in    (pix_l),
		.luma_in   (luma_l),
		.dn_valid  (c_valid),
		.dn_ready  (a_ready),
		.pix_out   (pix_c),
		.alpha_out (alpha_c),
		.beta_out  (beta_c)
	);

	blcb_apply u_apply (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c_valid),
		.up_ready (a_ready),
		.pix_in   (pix_c),
		.alpha_in (alpha_c),
		.beta_in  (beta_c),
		.dn_valid (out_valid),
		.dn_ready (!out_stall),
		.pix_out  (pix_o)
	);

	assign red_out   = pix_o.red;
	assign green_out = pix_o.green;
	assign blue_out  = pix_o.blue;

endmodule
